FILE: rtl/madi_pkg.sv
// ----------------------------------------------------------------------------
// madi_pkg
// Shared types and constants of the moving average deadzone integrator.
// ----------------------------------------------------------------------------
package madi_pkg;

  localparam int ANG_W       = 15;
  localparam int CFG_W       = 14;
  localparam int EXT_W       = 17;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 1;

  localparam int ROLL_WINDOW_DEF  = 27;
  localparam int PITCH_WINDOW_DEF = 47;

  localparam logic [CFG_W-1:0] DEAD_BAND_RST   = 14'd64;
  localparam logic [CFG_W-1:0] ANGLE_LIMIT_RST = 14'd1280;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEAD_BAND   = 1'b0,
    REG_ANGLE_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    L_IDLE,
    L_UPD,
    L_START,
    L_DIV,
    L_DONE
  } lane_state_e;

  typedef struct packed {
    logic                    idle;
    logic                    done;
    logic signed [ANG_W-1:0] step;
    logic signed [ANG_W-1:0] sample;
  } lane_res_t;

endpackage

FILE: rtl/madi_div.sv
// ----------------------------------------------------------------------------
// madi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module madi_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/madi_lane.sv
// ----------------------------------------------------------------------------
// madi_lane
// One moving average lane: sample window, running sum, tenth of the mean.
// ----------------------------------------------------------------------------
module madi_lane #(
  parameter int DEPTH = 27
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [madi_pkg::ANG_W-1:0] sample_i,
  input  logic                          release_i,
  output madi_pkg::lane_res_t           res_o
);

  import madi_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = ANG_W + FILL_W;
  localparam int DEN_W  = FILL_W + 4;

  lane_state_e state_q, state_d;

  logic signed [ANG_W-1:0] mem [DEPTH];
  logic signed [ANG_W-1:0] rdata_q;
  logic signed [ANG_W-1:0] sample_q;
  logic signed [ANG_W-1:0] step_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic                    full;
  logic                    mem_we;
  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quo;
  logic [SUM_W-1:0]        mag;
  logic [DEN_W-1:0]        den;
  logic [DEN_W-1:0]        fill_ext;

  assign full     = fill_q == FILL_W'(DEPTH);
  assign mag      = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign fill_ext = DEN_W'(fill_q);
  assign den      = (fill_ext << 3) + (fill_ext << 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE:  if (start_i) state_d = L_UPD;
      L_UPD:   state_d = L_START;
      L_START: state_d = L_DIV;
      L_DIV:   if (div_done) state_d = L_DONE;
      L_DONE:  if (release_i) state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_comb begin
    mem_we       = 1'b0;
    div_start    = 1'b0;
    res_o.idle   = 1'b0;
    res_o.done   = 1'b0;
    res_o.step   = step_q;
    res_o.sample = sample_q;
    unique case (state_q)
      L_IDLE:  res_o.idle = 1'b1;
      L_UPD:   mem_we     = 1'b1;
      L_START: div_start  = 1'b1;
      L_DIV:   ;
      L_DONE:  res_o.done = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    sum_d  = sum_q;
    fill_d = fill_q;
    slot_d = slot_q;
    if (mem_we) begin
      sum_d = sum_q + SUM_W'(sample_q) - (full ? SUM_W'(rdata_q) : SUM_W'(0));
      if (!full) begin
        fill_d = fill_q + FILL_W'(1);
      end
      slot_d = (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      sum_q   <= '0;
      fill_q  <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      fill_q  <= fill_d;
      slot_q  <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && res_o.idle) begin
      sample_q <= sample_i;
    end
    if (state_q == L_DIV && div_done) begin
      step_q <= sum_q[SUM_W-1] ? -$signed(div_quo[ANG_W-1:0])
                               : $signed(div_quo[ANG_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot_q] <= sample_q;
    end
    rdata_q <= mem[slot_q];
  end

  madi_div #(
    .NUM_W(SUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (mag),
    .den_i  (den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(DEPTH))
    else $error("fill count beyond window depth");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(DEPTH - 1))
    else $error("window slot out of range");

endmodule

FILE: rtl/madi_merge.sv
// ----------------------------------------------------------------------------
// madi_merge
// Combine both lanes: deadzone test, integrate, clamp, output register.
// ----------------------------------------------------------------------------
module madi_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  madi_pkg::lane_res_t            roll_i,
  input  madi_pkg::lane_res_t            pitch_i,
  input  logic [madi_pkg::CFG_W-1:0]     dead_band_i,
  input  logic [madi_pkg::CFG_W-1:0]     angle_limit_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [madi_pkg::ANG_W-1:0] pitch_target_o,
  output logic signed [madi_pkg::ANG_W-1:0] roll_target_o,
  output logic                           release_o
);

  import madi_pkg::*;

  logic                    fire;
  logic                    out_valid_q, out_valid_d;
  logic signed [ANG_W-1:0] pitch_int_q, pitch_int_d;
  logic signed [ANG_W-1:0] roll_int_q, roll_int_d;
  logic signed [EXT_W-1:0] lim_pos;
  logic signed [EXT_W-1:0] lim_neg;
  logic signed [EXT_W-1:0] db_pos;
  logic signed [EXT_W-1:0] db_neg;
  logic signed [EXT_W-1:0] pitch_raw;
  logic signed [EXT_W-1:0] roll_raw;
  logic                    roll_out;
  logic                    pitch_out;

  assign lim_pos = $signed(EXT_W'(angle_limit_i));
  assign lim_neg = -lim_pos;
  assign db_pos  = $signed(EXT_W'(dead_band_i));
  assign db_neg  = -db_pos;

  assign roll_out  = (EXT_W'(roll_i.sample) > db_pos) || (EXT_W'(roll_i.sample) < db_neg);
  assign pitch_out = (EXT_W'(pitch_i.sample) > db_pos) || (EXT_W'(pitch_i.sample) < db_neg);

  assign pitch_raw = roll_out ? EXT_W'(pitch_int_q) - EXT_W'(roll_i.step)
                              : EXT_W'(pitch_int_q);
  assign roll_raw  = pitch_out ? EXT_W'(roll_int_q) - EXT_W'(pitch_i.step)
                               : EXT_W'(roll_int_q);

  assign fire = roll_i.done && pitch_i.done && (!out_valid_q || out_ready_i);

  always_comb begin
    pitch_int_d = pitch_int_q;
    roll_int_d  = roll_int_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (fire) begin
      out_valid_d = 1'b1;
      if (pitch_raw > lim_pos) begin
        pitch_int_d = lim_pos[ANG_W-1:0];
      end else if (pitch_raw < lim_neg) begin
        pitch_int_d = lim_neg[ANG_W-1:0];
      end else begin
        pitch_int_d = pitch_raw[ANG_W-1:0];
      end
      if (roll_raw > lim_pos) begin
        roll_int_d = lim_pos[ANG_W-1:0];
      end else if (roll_raw < lim_neg) begin
        roll_int_d = lim_neg[ANG_W-1:0];
      end else begin
        roll_int_d = roll_raw[ANG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pitch_int_q <= '0;
      roll_int_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      pitch_int_q <= pitch_int_d;
      roll_int_q  <= roll_int_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pitch_target_o = pitch_int_q;
  assign roll_target_o  = roll_int_q;
  assign release_o      = fire;

  a_pitch_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (EXT_W'(pitch_int_q) <= lim_pos) && (EXT_W'(pitch_int_q) >= lim_neg))
    else $error("pitch integrator outside limit");

  a_roll_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (EXT_W'(roll_int_q) <= lim_pos) && (EXT_W'(roll_int_q) >= lim_neg))
    else $error("roll integrator outside limit");

endmodule

FILE: rtl/moving_average_deadzone_integrator.sv
// ----------------------------------------------------------------------------
// moving_average_deadzone_integrator
// Cross-coupled moving average deadzone integrator for roll and pitch.
//
// Input stream: one beat carries a roll and a pitch sample (1/64 degree).
// Output stream: one beat per input beat with the pitch and roll targets.
// Config port: write dead_band (index 0) or angle_limit (index 1) while idle.
// Each angle runs in its own lane: a sample window, running sum and a
// one-bit-per-cycle divider for the tenth of the mean. The merge stage
// applies the deadzone, integrates, clamps and loads the output register.
// A beat is taken only while both lanes are idle. Each lane then updates its
// window and sum, starts its divider and holds its result until the merge
// stage takes both; the lane with the wider window finishes its division last.
// A new beat is taken as soon as both lanes hand off, while the previous
// result still waits.
// Reset clears sums, fill counts, slots and integrators; window contents
// are left undefined and are read only after being written.
// When the receiver stalls, the result holds and one more beat can be
// worked up to the merge stage, after which the input stalls too.
// ----------------------------------------------------------------------------
module moving_average_deadzone_integrator #(
  parameter int ROLL_WINDOW  = madi_pkg::ROLL_WINDOW_DEF,
  parameter int PITCH_WINDOW = madi_pkg::PITCH_WINDOW_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // roll_angle [14:0], pitch_angle [29:15], zero [31:30]
  input  logic [madi_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pitch_target [14:0], roll_target [29:15], zero [31:30]
  output logic [madi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [madi_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [madi_pkg::CFG_W-1:0]        cfg_wdata_i
);

  import madi_pkg::*;

  lane_res_t               roll_res;
  lane_res_t               pitch_res;
  logic                    in_take;
  logic                    release_w;
  logic [CFG_W-1:0]        dead_band_q;
  logic [CFG_W-1:0]        angle_limit_q;
  logic signed [ANG_W-1:0] pitch_target;
  logic signed [ANG_W-1:0] roll_target;

  assign s_axis_tready = roll_res.idle && pitch_res.idle;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_band_q   <= DEAD_BAND_RST;
      angle_limit_q <= ANGLE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_DEAD_BAND:   dead_band_q   <= cfg_wdata_i;
        REG_ANGLE_LIMIT: angle_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  madi_lane #(
    .DEPTH(ROLL_WINDOW)
  ) u_roll_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_take),
    .sample_i ($signed(s_axis_tdata[ANG_W-1:0])),
    .release_i(release_w),
    .res_o    (roll_res)
  );

  madi_lane #(
    .DEPTH(PITCH_WINDOW)
  ) u_pitch_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_take),
    .sample_i ($signed(s_axis_tdata[2*ANG_W-1:ANG_W])),
    .release_i(release_w),
    .res_o    (pitch_res)
  );

  madi_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .roll_i        (roll_res),
    .pitch_i       (pitch_res),
    .dead_band_i   (dead_band_q),
    .angle_limit_i (angle_limit_q),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .pitch_target_o(pitch_target),
    .roll_target_o (roll_target),
    .release_o     (release_w)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - 2*ANG_W){1'b0}}, roll_target, pitch_target};

endmodule

FILE: sim/tb_moving_average_deadzone_integrator.sv
// ----------------------------------------------------------------------------
// tb_moving_average_deadzone_integrator
// Self-checking bench for the roll/pitch moving average deadzone integrator.
// A directed table walks the range extremes, the deadzone edges and the
// clamp settings. Random phases follow, each with its own register setting.
// Every accepted input beat runs through a local model of both averaging
// windows and both integrators. Every output beat is compared, field by
// field, with the oldest expected pair of targets. Both stream sides stall
// in random bursts, except in the final phase.
// ----------------------------------------------------------------------------
module tb_moving_average_deadzone_integrator;
  import madi_pkg::*;

  localparam int PHASES      = 7;
  localparam int PHASE_BEATS = 200;
  localparam int SETTLE      = 40;
  localparam int PRINT_CAP   = 100;
  localparam int PLAN_ROWS   = 32;
  localparam int EXP_DEPTH   = 8;

  typedef struct packed {
    logic signed [ANG_W-1:0] roll_target;
    logic signed [ANG_W-1:0] pitch_target;
  } targets_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    cfg_reg_e                sel;
    logic [CFG_W-1:0]        value;
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
    bit                      typed;
    targets_t                want;
  } plan_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_W-1:0]      cfg_wdata_i   = '0;

  // Window state, lane 0 is roll and lane 1 is pitch
  int               lane_depth [2] = '{ROLL_WINDOW_DEF, PITCH_WINDOW_DEF};
  int               lane_hist  [2][PITCH_WINDOW_DEF];
  int               lane_sum   [2] = '{0, 0};
  int               lane_fill  [2] = '{0, 0};
  int               lane_slot  [2] = '{0, 0};
  int               pitch_int      = 0;
  int               roll_int       = 0;
  logic [CFG_W-1:0] band_q         = DEAD_BAND_RST;
  logic [CFG_W-1:0] limit_q        = ANGLE_LIMIT_RST;

  targets_t  expected [EXP_DEPTH];
  int        exp_wr          = 0;
  int        exp_rd          = 0;
  plan_row_t plan [PLAN_ROWS];
  int        plan_len        = 0;
  bit        idle_on         = 1'b1;
  int        mismatches      = 0;
  int        beats_sent      = 0;
  int        directed_beats  = 0;
  int        results_checked = 0;
  int        cfg_writes      = 0;
  int        drains          = 0;

  moving_average_deadzone_integrator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic bit beyond_band(int a);
    int lim;
    lim = int'(band_q);
    return (a > lim) || (a < -lim);
  endfunction

  function automatic int clamp_to_limit(int v);
    int lim;
    lim = int'(limit_q);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void advance_targets(input logic signed [ANG_W-1:0] roll,
                                          input logic signed [ANG_W-1:0] pitch,
                                          output targets_t res);
    int smp   [2];
    int tenth [2];
    int mag;
    smp[0] = int'(roll);
    smp[1] = int'(pitch);
    for (int l = 0; l < 2; l++) begin
      if (lane_fill[l] >= lane_depth[l]) lane_sum[l] -= lane_hist[l][lane_slot[l]];
      else lane_fill[l]++;
      lane_hist[l][lane_slot[l]] = smp[l];
      lane_sum[l] += smp[l];
      lane_slot[l] = (lane_slot[l] + 1 == lane_depth[l]) ? 0 : lane_slot[l] + 1;
      mag = (lane_sum[l] < 0) ? -lane_sum[l] : lane_sum[l];
      tenth[l] = mag / (lane_fill[l] * 10);
      if (lane_sum[l] < 0) tenth[l] = -tenth[l];
    end
    if (beyond_band(int'(roll))) pitch_int -= tenth[0];
    pitch_int = clamp_to_limit(pitch_int);
    if (beyond_band(int'(pitch))) roll_int -= tenth[1];
    roll_int = clamp_to_limit(roll_int);
    res.pitch_target = pitch_int[ANG_W-1:0];
    res.roll_target  = roll_int[ANG_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    targets_t got;
    targets_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pitch_target = m_axis_tdata[ANG_W-1:0];
      got.roll_target  = m_axis_tdata[2*ANG_W-1:ANG_W];
      if (exp_wr == exp_rd) begin
        report_mismatch($sformatf("unexpected beat pitch %0d roll %0d",
                                  got.pitch_target, got.roll_target));
      end else begin
        want = expected[exp_rd % EXP_DEPTH];
        exp_rd++;
        results_checked++;
        if (got.pitch_target !== want.pitch_target)
          report_mismatch($sformatf("result %0d pitch_target %0d, want %0d",
                                    results_checked, got.pitch_target, want.pitch_target));
        if (got.roll_target !== want.roll_target)
          report_mismatch($sformatf("result %0d roll_target %0d, want %0d",
                                    results_checked, got.roll_target, want.roll_target));
      end
    end
  end

  // Receiver: stall in bursts while idling is on
  initial begin
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  task automatic send_beat(input logic signed [ANG_W-1:0] roll,
                           input logic signed [ANG_W-1:0] pitch,
                           input bit typed, input targets_t want);
    targets_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, pitch, roll};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_targets(roll, pitch, predicted);
    expected[exp_wr % EXP_DEPTH] = typed ? want : predicted;
    exp_wr++;
    beats_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    drains++;
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= sel;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      REG_DEAD_BAND:   band_q  = value;
      REG_ANGLE_LIMIT: limit_q = value;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  function automatic plan_row_t beat_row(int roll, int pitch, bit typed = 1'b0,
                                         int want_pitch = 0, int want_roll = 0);
    plan_row_t r;
    r.kind               = ROW_BEAT;
    r.sel                = REG_DEAD_BAND;
    r.value              = '0;
    r.roll               = roll[ANG_W-1:0];
    r.pitch              = pitch[ANG_W-1:0];
    r.typed              = typed;
    r.want.pitch_target  = want_pitch[ANG_W-1:0];
    r.want.roll_target   = want_roll[ANG_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t write_row(cfg_reg_e sel, int value);
    plan_row_t r;
    r       = beat_row(0, 0);
    r.kind  = ROW_WRITE;
    r.sel   = sel;
    r.value = value[CFG_W-1:0];
    return r;
  endfunction

  function automatic void add_row(input plan_row_t r);
    plan[plan_len] = r;
    plan_len++;
  endfunction

  function automatic logic [CFG_W-1:0] pick_setting();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 14'd11520;
      3:       return CFG_W'($urandom_range(0, 300));
      default: return CFG_W'($urandom_range(0, 16383));
    endcase
  endfunction

  function automatic logic signed [ANG_W-1:0] draw_angle(int bias);
    int v;
    int band;
    band = int'(band_q);
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 32767));
      3, 4, 5: begin
        v = bias + int'($urandom_range(0, 8000)) - 4000;
        if (v > 11520) v = 11520;
        if (v < -11520) v = -11520;
      end
      6, 7: begin
        v = band + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) v = -v;
      end
      8: v = int'($urandom_range(0, 400)) - 200;
      default: begin
        case ($urandom_range(0, 4))
          0:       v = -16384;
          1:       v = 16383;
          2:       v = -11520;
          3:       v = 11520;
          default: v = 0;
        endcase
      end
    endcase
    return v[ANG_W-1:0];
  endfunction

  initial begin
    int bias;
    add_row(beat_row(0, 0, 1'b1, 0, 0));
    add_row(beat_row(11520, -11520, 1'b1, -576, 576));
    add_row(beat_row(-11520, 11520));
    add_row(beat_row(64, -64));
    add_row(beat_row(65, -65));
    add_row(beat_row(-64, 64));
    add_row(beat_row(-16384, 16383));
    add_row(beat_row(16383, -16384));
    add_row(write_row(REG_ANGLE_LIMIT, 0));
    add_row(beat_row(11520, 11520, 1'b1, 0, 0));
    add_row(beat_row(-16384, -16384, 1'b1, 0, 0));
    add_row(write_row(REG_ANGLE_LIMIT, 16383));
    add_row(write_row(REG_DEAD_BAND, 0));
    add_row(beat_row(1, -1));
    add_row(beat_row(0, 0));
    add_row(beat_row(-16384, -16384));
    add_row(write_row(REG_DEAD_BAND, 16383));
    add_row(beat_row(16383, -16384));
    add_row(write_row(REG_DEAD_BAND, 11520));
    add_row(write_row(REG_ANGLE_LIMIT, 100));
    add_row(beat_row(11521, -11521));
    add_row(beat_row(-11520, 11520));
    add_row(write_row(REG_DEAD_BAND, DEAD_BAND_RST));
    add_row(write_row(REG_ANGLE_LIMIT, ANGLE_LIMIT_RST));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < plan_len; i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(plan[i].sel, plan[i].value);
      end else begin
        send_beat(plan[i].roll, plan[i].pitch, plan[i].typed, plan[i].want);
        directed_beats++;
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == PHASES - 1) begin
        idle_on = 1'b0;
        write_reg(REG_DEAD_BAND, DEAD_BAND_RST);
        write_reg(REG_ANGLE_LIMIT, ANGLE_LIMIT_RST);
      end else begin
        write_reg(REG_DEAD_BAND, pick_setting());
        write_reg(REG_ANGLE_LIMIT, pick_setting());
      end
      bias = int'($urandom_range(0, 12000)) - 6000;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n == PHASE_BEATS / 2 && $urandom_range(0, 1)) wait_drained();
        send_beat(draw_angle(bias), draw_angle(bias), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);

    $display("Sent %0d beats (%0d from the directed table), checked %0d results",
             beats_sent, directed_beats, results_checked);
    $display("Used %0d register writes over %0d phases, %0d full drains",
             cfg_writes, PHASES, drains);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/madi_pkg.sv
rtl/madi_div.sv
rtl/madi_lane.sv
rtl/madi_merge.sv
rtl/moving_average_deadzone_integrator.sv
sim/tb_moving_average_deadzone_integrator.sv
